@@ design/hrr_pkg.sv @@
package hrr_pkg;

  // fixed levels of the rainbow hue map
  localparam logic [7:0] LEVEL_FULL       = 8'd255;
  localparam logic [7:0] LEVEL_TWO_THIRDS = 8'd170;
  localparam logic [7:0] LEVEL_TWO_THIRDS_UP = 8'd171;
  localparam logic [7:0] LEVEL_THIRD      = 8'd85;
  localparam logic [4:0] OFFSET_MASK      = 5'h1F;

  // segments of the hue wheel, selected by the top three hue bits
  typedef enum logic [2:0] {
    SEG_RED_ORANGE    = 3'd0,
    SEG_ORANGE_YELLOW = 3'd1,
    SEG_YELLOW_GREEN  = 3'd2,
    SEG_GREEN_AQUA    = 3'd3,
    SEG_AQUA_BLUE     = 3'd4,
    SEG_BLUE_PURPLE   = 3'd5,
    SEG_PURPLE_PINK   = 3'd6,
    SEG_PINK_RED      = 3'd7
  } seg_t;

  // pixel after the hue map, with the terms the later stages need
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] floor8;
  } mapped_t;

  // (a * (1 + b)) >> 8, the product never exceeds 16 bits
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] prod;
    prod = 17'(a) * (17'(b) + 17'd1);
    return prod[15:8];
  endfunction

endpackage

@@ design/hrr_hue_map.sv @@
module hrr_hue_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          hue,
  input  logic [7:0]          saturation,
  input  logic [7:0]          brightness,
  output logic                out_valid,
  output hrr_pkg::mapped_t    mapped
);

  // stage 1 registers
  logic                 valid1;
  hrr_pkg::seg_t        seg1;
  logic [7:0]           t1;
  logic [7:0]           t2;
  logic [7:0]           sat1;
  logic [7:0]           val1;
  logic [7:0]           floor1;

  logic [7:0]           ofs;
  logic [7:0]           desat;
  hrr_pkg::mapped_t     mapped_next;

  assign ofs   = {hue[4:0] & hrr_pkg::OFFSET_MASK, 3'b000};
  assign desat = hrr_pkg::LEVEL_FULL - saturation;

  // stage 1: thirds of the offset and the desaturation floor
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    seg1   <= hrr_pkg::seg_t'(hue[7:5]);
    t1     <= hrr_pkg::scale8(ofs, hrr_pkg::LEVEL_THIRD);
    t2     <= hrr_pkg::scale8(ofs, hrr_pkg::LEVEL_TWO_THIRDS);
    sat1   <= saturation;
    val1   <= brightness;
    floor1 <= hrr_pkg::scale8(desat, desat);
  end

  // segment select
  always_comb begin
    mapped_next        = '0;
    mapped_next.sat    = sat1;
    mapped_next.val    = val1;
    mapped_next.floor8 = floor1;
    mapped_next.white  = 8'd0;
    unique case (seg1)
      hrr_pkg::SEG_RED_ORANGE: begin
        mapped_next.red   = hrr_pkg::LEVEL_FULL - t1;
        mapped_next.green = t1;
        mapped_next.blue  = 8'd0;
      end
      hrr_pkg::SEG_ORANGE_YELLOW: begin
        mapped_next.red   = hrr_pkg::LEVEL_TWO_THIRDS_UP;
        mapped_next.green = hrr_pkg::LEVEL_THIRD + t1;
        mapped_next.blue  = 8'd0;
      end
      hrr_pkg::SEG_YELLOW_GREEN: begin
        mapped_next.red   = hrr_pkg::LEVEL_TWO_THIRDS_UP - t2;
        mapped_next.green = hrr_pkg::LEVEL_TWO_THIRDS + t1;
        mapped_next.blue  = 8'd0;
      end
      hrr_pkg::SEG_GREEN_AQUA: begin
        mapped_next.red   = 8'd0;
        mapped_next.green = hrr_pkg::LEVEL_FULL - t1;
        mapped_next.blue  = t1;
      end
      hrr_pkg::SEG_AQUA_BLUE: begin
        mapped_next.red   = 8'd0;
        mapped_next.green = hrr_pkg::LEVEL_TWO_THIRDS_UP - t2;
        mapped_next.blue  = hrr_pkg::LEVEL_THIRD + t2;
      end
      hrr_pkg::SEG_BLUE_PURPLE: begin
        mapped_next.red   = t1;
        mapped_next.green = 8'd0;
        mapped_next.blue  = hrr_pkg::LEVEL_FULL - t1;
      end
      hrr_pkg::SEG_PURPLE_PINK: begin
        mapped_next.red   = hrr_pkg::LEVEL_THIRD + t1;
        mapped_next.green = 8'd0;
        mapped_next.blue  = hrr_pkg::LEVEL_TWO_THIRDS_UP - t1;
      end
      hrr_pkg::SEG_PINK_RED: begin
        mapped_next.red   = hrr_pkg::LEVEL_TWO_THIRDS + t1;
        mapped_next.green = 8'd0;
        mapped_next.blue  = hrr_pkg::LEVEL_THIRD - t1;
      end
      default: begin
        mapped_next.red   = 8'd0;
        mapped_next.green = 8'd0;
        mapped_next.blue  = 8'd0;
      end
    endcase
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
    mapped <= mapped_next;
  end

endmodule

@@ design/hrr_chan.sv @@
module hrr_chan (
  input  logic       clk,
  input  logic [7:0] level,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  input  logic [7:0] floor8,
  output logic [7:0] result
);

  logic [7:0] scaled;
  logic [7:0] floor_d;
  logic [7:0] val_d;
  logic [7:0] val_dd;
  logic [7:0] summed;
  logic [8:0] sum_wide;

  // stage 3: scale by saturation
  always_ff @(posedge clk) begin
    scaled  <= hrr_pkg::scale8(level, sat);
    floor_d <= floor8;
    val_d   <= val;
  end

  // stage 4: add the desaturation floor, clamped at full scale
  assign sum_wide = {1'b0, scaled} + {1'b0, floor_d};

  always_ff @(posedge clk) begin
    summed <= sum_wide[8] ? hrr_pkg::LEVEL_FULL : sum_wide[7:0];
    val_dd <= val_d;
  end

  // stage 5: scale by brightness
  always_ff @(posedge clk) begin
    result <= hrr_pkg::scale8(summed, val_dd);
  end

endmodule

@@ design/hsv_rainbow_to_rgb.sv @@
// Rainbow HSV to RGBW converter. One transaction is taken on every clock
// cycle that start is high; busy never rises, as the block is a five-stage
// pipeline (hue map in two stages, then saturation scale, floor add and
// brightness scale per channel, one stage each). The result appears on
// red, green, blue and white with done high once it leaves the last stage,
// for one cycle only, in input order; the receiver cannot stall
// it and must take it then.
module hsv_rainbow_to_rgb (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] white
);

  logic             map_valid;
  hrr_pkg::mapped_t mapped;
  logic             valid3;
  logic             valid4;

  assign busy = 1'b0;

  // hue map, stages 1 and 2
  hrr_hue_map u_hue_map (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (map_valid),
    .mapped     (mapped)
  );

  // per-channel scaling, stages 3 to 5
  hrr_chan u_chan_red (
    .clk (clk), .level (mapped.red), .sat (mapped.sat), .val (mapped.val),
    .floor8 (mapped.floor8), .result (red)
  );
  hrr_chan u_chan_green (
    .clk (clk), .level (mapped.green), .sat (mapped.sat), .val (mapped.val),
    .floor8 (mapped.floor8), .result (green)
  );
  hrr_chan u_chan_blue (
    .clk (clk), .level (mapped.blue), .sat (mapped.sat), .val (mapped.val),
    .floor8 (mapped.floor8), .result (blue)
  );
  hrr_chan u_chan_white (
    .clk (clk), .level (mapped.white), .sat (mapped.sat), .val (mapped.val),
    .floor8 (mapped.floor8), .result (white)
  );

  // valid bits alongside the channel stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid3 <= map_valid;
      valid4 <= valid3;
      done   <= valid4;
    end
  end

  // every transaction comes out with done high
  assert property (@(posedge clk) disable iff (rst) start |-> ##5 done)
    else $error("transaction lost in pipeline");

  // pure hue leaves no white
  assert property (@(posedge clk) disable iff (rst)
    start && (saturation == 8'd255) |-> ##5 (white == 8'd0))
    else $error("white nonzero at full saturation");

  // zero brightness gives a black pixel
  assert property (@(posedge clk) disable iff (rst)
    start && (brightness == 8'd0) |-> ##5
      (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) && (white == 8'd0))
    else $error("pixel not black at zero brightness");

endmodule

@@ sim/hsv_rainbow_to_rgb_tb.sv @@
`timescale 1ns / 100ps

module hsv_rainbow_to_rgb_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } rgbw_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    logic       typed;
    rgbw_t      want;
  } pixel_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam int ITEMS_PER_PHASE = 360;
  localparam rgbw_t BLACK = '{8'd0, 8'd0, 8'd0, 8'd0};
  localparam rgbw_t FULL_WHITE = '{8'd255, 8'd255, 8'd255, 8'd255};
  localparam rgbw_t PURE_RED = '{8'd255, 8'd0, 8'd0, 8'd0};

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       done;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] white;

  // hand-typed expectation travelling with the current transaction
  logic       row_typed;
  rgbw_t      typed_pix;

  rgbw_t pending_pixels [$];
  int    error_count = 0;

  // directed rows: extremes typed in, the rest predicted
  pixel_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'd0,   8'd255, 8'd255, 1'b1, PURE_RED},
    '{8'd0,   8'd255, 8'd0,   1'b1, BLACK},
    '{8'd255, 8'd255, 8'd0,   1'b1, BLACK},
    '{8'd0,   8'd0,   8'd255, 1'b1, FULL_WHITE},
    '{8'd200, 8'd0,   8'd255, 1'b1, FULL_WHITE},
    '{8'd255, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd16,  8'd255, 8'd255, 1'b0, BLACK},
    '{8'd48,  8'd255, 8'd255, 1'b0, BLACK},
    '{8'd80,  8'd255, 8'd255, 1'b0, BLACK},
    '{8'd112, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd144, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd176, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd208, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd240, 8'd255, 8'd255, 1'b0, BLACK},
    '{8'd31,  8'd200, 8'd128, 1'b0, BLACK},
    '{8'd32,  8'd255, 8'd255, 1'b0, BLACK},
    '{8'd95,  8'd1,   8'd254, 1'b0, BLACK},
    '{8'd128, 8'd254, 8'd1,   1'b0, BLACK},
    '{8'd160, 8'd128, 8'd128, 1'b0, BLACK},
    '{8'd224, 8'd127, 8'd200, 1'b0, BLACK},
    '{8'd96,  8'd64,  8'd255, 1'b0, BLACK},
    '{8'd191, 8'd192, 8'd64,  1'b0, BLACK}
  };

  hsv_rainbow_to_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .white      (white)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fractional multiply, (a * (b + 1)) >> 8
  function automatic logic [7:0] frac_scale(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] prod;
    prod = {9'd0, a} * ({9'd0, b} + 17'd1);
    return prod[15:8];
  endfunction

  // expected pixel for one hue / saturation / brightness transaction
  function automatic rgbw_t rainbow_pixel(input logic [7:0] h, input logic [7:0] s,
                                          input logic [7:0] v);
    logic [7:0] ofs;
    logic [7:0] third;
    logic [7:0] third_hi;
    logic [7:0] floor_lvl;
    logic [7:0] lvl;
    logic [8:0] sum;
    logic [7:0] chan [4];
    rgbw_t      pix;
    int         i;
    ofs = {h[4:0], 3'b000};
    third = frac_scale(ofs, hrr_pkg::LEVEL_THIRD);
    third_hi = frac_scale(ofs, hrr_pkg::LEVEL_TWO_THIRDS);
    chan[3] = 8'd0;
    case (hrr_pkg::seg_t'(h[7:5]))
      hrr_pkg::SEG_RED_ORANGE: begin
        chan[0] = hrr_pkg::LEVEL_FULL - third; chan[1] = third; chan[2] = 8'd0;
      end
      hrr_pkg::SEG_ORANGE_YELLOW: begin
        chan[0] = hrr_pkg::LEVEL_TWO_THIRDS_UP;
        chan[1] = hrr_pkg::LEVEL_THIRD + third;
        chan[2] = 8'd0;
      end
      hrr_pkg::SEG_YELLOW_GREEN: begin
        chan[0] = hrr_pkg::LEVEL_TWO_THIRDS_UP - third_hi;
        chan[1] = hrr_pkg::LEVEL_TWO_THIRDS + third;
        chan[2] = 8'd0;
      end
      hrr_pkg::SEG_GREEN_AQUA: begin
        chan[0] = 8'd0; chan[1] = hrr_pkg::LEVEL_FULL - third; chan[2] = third;
      end
      hrr_pkg::SEG_AQUA_BLUE: begin
        chan[0] = 8'd0;
        chan[1] = hrr_pkg::LEVEL_TWO_THIRDS_UP - third_hi;
        chan[2] = hrr_pkg::LEVEL_THIRD + third_hi;
      end
      hrr_pkg::SEG_BLUE_PURPLE: begin
        chan[0] = third; chan[1] = 8'd0; chan[2] = hrr_pkg::LEVEL_FULL - third;
      end
      hrr_pkg::SEG_PURPLE_PINK: begin
        chan[0] = hrr_pkg::LEVEL_THIRD + third;
        chan[1] = 8'd0;
        chan[2] = hrr_pkg::LEVEL_TWO_THIRDS_UP - third;
      end
      default: begin
        chan[0] = hrr_pkg::LEVEL_TWO_THIRDS + third;
        chan[1] = 8'd0;
        chan[2] = hrr_pkg::LEVEL_THIRD - third;
      end
    endcase
    // desaturation floor, then saturating add, then brightness
    floor_lvl = frac_scale(~s, ~s);
    for (i = 0; i < 4; i++) begin
      lvl = frac_scale(chan[i], s);
      sum = {1'b0, lvl} + {1'b0, floor_lvl};
      lvl = sum[8] ? 8'hFF : sum[7:0];
      chan[i] = frac_scale(lvl, v);
    end
    pix.red = chan[0];
    pix.green = chan[1];
    pix.blue = chan[2];
    pix.white = chan[3];
    return pix;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // record accepted transactions and check results against the oldest one
  always @(posedge clk) begin : scoreboard
    rgbw_t want;
    if (!rst) begin
      if (start && !busy)
        pending_pixels.push_back(row_typed ? typed_pix :
                                 rainbow_pixel(hue, saturation, brightness));
      if (done) begin
        if (pending_pixels.size() == 0) begin
          flag_mismatch("result with no pending transaction");
        end else begin
          want = pending_pixels.pop_front();
          if (red !== want.red)
            flag_mismatch($sformatf("red got %0d want %0d", red, want.red));
          if (green !== want.green)
            flag_mismatch($sformatf("green got %0d want %0d", green, want.green));
          if (blue !== want.blue)
            flag_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
          if (white !== want.white)
            flag_mismatch($sformatf("white got %0d want %0d", white, want.white));
        end
      end
    end
  end

  // drive one transaction and hold it until the block takes it
  task automatic issue_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                             input logic typed, input rgbw_t want);
    @(negedge clk);
    start <= 1'b1;
    hue <= h;
    saturation <= s;
    brightness <= v;
    row_typed <= typed;
    typed_pix <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drive start low and put noise on the fields
  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    hue <= 8'($urandom);
    saturation <= 8'($urandom);
    brightness <= 8'($urandom);
    row_typed <= 1'b0;
  endtask

  // hold off the sender until every pending result is back or the wait times out
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    idle_cycle();
    while (pending_pixels.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // biased level: extremes often, anything otherwise
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // stimulus
  initial begin
    int idle_pct [3];
    int n;
    int ph;
    idle_pct = '{15, 73, 0};
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    hue = 8'd0;
    saturation = 8'd0;
    brightness = 8'd0;
    row_typed = 1'b0;
    typed_pix = BLACK;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, back to back
    for (n = 0; n < NUM_DIRECTED; n++)
      issue_pixel(directed_rows[n].hue, directed_rows[n].sat, directed_rows[n].bri,
                  directed_rows[n].typed, directed_rows[n].want);
    drain_pipeline();

    // random phases with different sender gaps
    for (ph = 0; ph < 3; ph++) begin
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        while ($urandom_range(0, 99) < idle_pct[ph]) idle_cycle();
        issue_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level(), 1'b0, BLACK);
      end
      drain_pipeline();
    end

    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
